// ===== rtl/scalar_kalman_filter_3axis_defines.svh =====
// Assertion macros shared by the filter modules.
`ifndef SCALAR_KALMAN_FILTER_3AXIS_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_3AXIS_DEFINES_SVH

// Same-cycle implication.
`define SKF3_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SKF3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/skf3_pkg.sv =====
// Package: constants, command/status types and config type for the filter.
package skf3_pkg;

   localparam int AXES      = 3;
   localparam int AXIS_W    = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int SAMPLE_W  = 16;
   localparam int CFG_W     = 16;
   localparam int EST_W     = 32;
   localparam int COV_W     = 24;
   localparam int FRAC_W    = 20;
   localparam int GAIN_W    = FRAC_W + 1;
   localparam int DEN_W     = COV_W + 1;
   localparam int REM_W     = DEN_W + 1;
   localparam int DIFF_W    = EST_W + 2;
   localparam int MUL_B_W   = GAIN_W + 1;
   localparam int PROD_W    = DIFF_W + MUL_B_W;
   localparam int DIV_STEPS = GAIN_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int CSR_IDX_W = 2;

   localparam logic [COV_W-1:0]  COV_MAX  = '1;
   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << FRAC_W;

   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASURE_NOISE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_ERROR = 2'd2;

   localparam logic [CFG_W-1:0] PROCESS_NOISE_RST = 16'd256;
   localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = 16'd246;
   localparam logic [CFG_W-1:0] INITIAL_ERROR_RST = 16'd901;

   typedef logic [AXES-1:0][SAMPLE_W-1:0] axis_vec_type;

   typedef struct packed {
      logic [CFG_W-1:0] q;
      logic [CFG_W-1:0] r;
      logic [CFG_W-1:0] p;
   } skf3_cfg_type;

   typedef struct packed {
      logic              load_sample;
      logic              prime;
      logic              cov_start;
      logic              div_step;
      logic              mul_axis;
      logic              acc_axis;
      logic              mul_cov;
      logic              cov_write;
      logic              out_load;
      logic [AXIS_W-1:0] axis;
   } skf3_cmd_type;

   typedef struct packed {
      logic primed;
      logic out_free;
   } skf3_status_type;

endpackage

// ===== rtl/skf3_req_if.sv =====
// Input channel interface: one three-axis sample per transaction.
interface skf3_req_if;
   import skf3_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_x;
   logic signed [SAMPLE_W-1:0] sample_y;
   logic signed [SAMPLE_W-1:0] sample_z;

   modport source (output valid, output sample_x, output sample_y, output sample_z,
                   input ready);
   modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                   output ready);
endinterface

// ===== rtl/skf3_rsp_if.sv =====
// Result channel interface: one three-axis filtered value per transaction.
interface skf3_rsp_if;
   import skf3_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] filtered_x;
   logic signed [SAMPLE_W-1:0] filtered_y;
   logic signed [SAMPLE_W-1:0] filtered_z;

   modport source (output valid, output filtered_x, output filtered_y, output filtered_z,
                   input ready);
   modport sink   (input valid, input filtered_x, input filtered_y, input filtered_z,
                   output ready);
endinterface

// ===== rtl/scalar_kalman_filter_3axis.sv =====
// Top level of the three-axis scalar Kalman filter.
// Usage:
//   req_ch carries one transaction per sensor sample (sample_x/y/z, int16).
//   rsp_ch returns exactly one transaction per request (filtered_x/y/z, int16).
//   csr_write_en/csr_index/csr_data write q (0), r (1), p (2), Q4.12; write
//   only while no transaction is in flight. Other indexes are ignored.
// Sequence: the first transaction after reset only primes the state and then
//   loads its result. Each later transaction runs a restoring divide for the
//   21-bit gain, then one shared multiplier for three axis updates and the
//   covariance update, and then loads its result.
// Flow: the block takes no new request until the current one has loaded its
//   result. req_ch.ready is high only while the controller is idle.
// Reset (synchronous, active high): the configuration registers return to
//   defaults, the filter is unprimed and no result is pending.
// Stall: a finished result sits in the output register while the next
//   request is processed; the block holds before loading a new result until
//   the pending one is taken.
module scalar_kalman_filter_3axis (
   input  logic                              clock,
   input  logic                              reset,
   skf3_req_if.sink                          req_ch,
   skf3_rsp_if.source                        rsp_ch,
   input  logic                              csr_write_en,
   input  logic [skf3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [skf3_pkg::CFG_W-1:0]        csr_data
);
   import skf3_pkg::*;

   skf3_cfg_type    cfg;
   skf3_cmd_type    cmd;
   skf3_status_type status;
   axis_vec_type    samples;
   axis_vec_type    filtered;
   logic            req_ready;
   logic            rsp_valid;

   assign samples[0] = req_ch.sample_x;
   assign samples[1] = req_ch.sample_y;
   assign samples[2] = req_ch.sample_z;

   skf3_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .cfg          (cfg)
   );

   skf3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   skf3_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .cfg       (cfg),
      .samples   (samples),
      .filtered  (filtered),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready)
   );

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid;
   assign rsp_ch.filtered_x = filtered[0];
   assign rsp_ch.filtered_y = filtered[1];
   assign rsp_ch.filtered_z = filtered[2];
endmodule

// ===== rtl/skf3_csr.sv =====
// Configuration registers: process noise, measurement noise, initial error.
module skf3_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [skf3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [skf3_pkg::CFG_W-1:0]        csr_data,
   output skf3_pkg::skf3_cfg_type            cfg
);
   import skf3_pkg::*;

   skf3_cfg_type cfg_ff;
   skf3_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_PROCESS_NOISE: cfg_in.q = csr_data;
            CSR_MEASURE_NOISE: cfg_in.r = csr_data;
            CSR_INITIAL_ERROR: cfg_in.p = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.q <= PROCESS_NOISE_RST;
         cfg_ff.r <= MEASURE_NOISE_RST;
         cfg_ff.p <= INITIAL_ERROR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

// ===== rtl/skf3_datapath.sv =====
// Datapath: estimates, covariance, restoring gain divider, shared multiplier, output register.
module skf3_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  skf3_pkg::skf3_cmd_type      cmd,
   output skf3_pkg::skf3_status_type   status,
   input  skf3_pkg::skf3_cfg_type      cfg,
   input  skf3_pkg::axis_vec_type      samples,
   output skf3_pkg::axis_vec_type      filtered,
   output logic                        rsp_valid,
   input  logic                        rsp_ready
);
   import skf3_pkg::*;
   `include "scalar_kalman_filter_3axis_defines.svh"

   axis_vec_type                   sample_ff, sample_in;
   logic [AXES-1:0][EST_W-1:0]     est_ff, est_in;
   logic [COV_W-1:0]               cov_ff, cov_in;
   logic [COV_W-1:0]               e1_ff, e1_in;
   logic [DEN_W-1:0]               den_ff, den_in;
   logic [REM_W-1:0]               rem_ff, rem_in;
   logic [GAIN_W-1:0]              k_ff, k_in;
   logic signed [PROD_W-1:0]       prod_ff, prod_in;
   axis_vec_type                   out_ff, out_in;
   logic                           primed_ff, primed_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [DEN_W-1:0]               cov_sum;
   logic [COV_W-1:0]               e1_sat;
   logic [DEN_W-1:0]               den_calc;
   logic                           rem_ge;
   logic [REM_W-1:0]               rem_sel;
   logic [EST_W-1:0]               est_sel;
   logic [EST_W-1:0]               meas;
   logic signed [DIFF_W-1:0]       diff;
   logic signed [DIFF_W-1:0]       mul_a;
   logic signed [MUL_B_W-1:0]      mul_b;
   logic signed [PROD_W-1:0]       prod_calc;
   logic [EST_W-1:0]               delta;

   // Round half to even, saturate at the top (the bottom cannot overflow).
   function automatic logic [SAMPLE_W-1:0] round_est(input logic [EST_W-1:0] est);
      logic [SAMPLE_W-1:0] whole;
      logic [EST_W-SAMPLE_W-1:0] frac;
      logic up;
      whole = est[EST_W-1:EST_W-SAMPLE_W];
      frac  = est[EST_W-SAMPLE_W-1:0];
      up    = (frac > 16'h8000) || ((frac == 16'h8000) && whole[0]);
      if (up && (whole != 16'h7FFF))
         return whole + 16'd1;
      return whole;
   endfunction

   assign cov_sum  = {1'b0, cov_ff} + {1'b0, cfg.q, 8'h00};
   assign e1_sat   = cov_sum[COV_W] ? COV_MAX : cov_sum[COV_W-1:0];
   assign den_calc = {1'b0, e1_sat} + {1'b0, cfg.r, 8'h00};

   assign rem_ge  = (rem_ff >= {1'b0, den_ff}) && (den_ff != '0);
   assign rem_sel = rem_ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;

   assign est_sel   = est_ff[cmd.axis];
   assign meas      = {sample_ff[cmd.axis], 16'h0000};
   assign diff      = DIFF_W'($signed(meas)) - DIFF_W'($signed(est_sel));
   assign mul_a     = cmd.mul_cov ? $signed(DIFF_W'({1'b0, e1_ff})) : diff;
   assign mul_b     = $signed({1'b0, cmd.mul_cov ? (GAIN_ONE - k_ff) : k_ff});
   assign prod_calc = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign delta     = prod_ff[FRAC_W+EST_W-1:FRAC_W];

   always_comb begin
      sample_in    = cmd.load_sample ? samples : sample_ff;
      e1_in        = cmd.cov_start ? e1_sat : e1_ff;
      den_in       = cmd.cov_start ? den_calc : den_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      prod_in      = (cmd.mul_axis || cmd.mul_cov) ? prod_calc : prod_ff;
      cov_in       = cov_ff;
      primed_in    = primed_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      est_in       = est_ff;

      if (cmd.cov_start) begin
         rem_in = REM_W'(e1_sat);
         k_in   = '0;
      end else if (cmd.div_step) begin
         rem_in = {rem_sel[REM_W-2:0], 1'b0};
         k_in   = {k_ff[GAIN_W-2:0], rem_ge};
      end

      if (cmd.prime) begin
         cov_in    = {cfg.p, 8'h00};
         primed_in = 1'b1;
      end else if (cmd.cov_write) begin
         cov_in = prod_ff[FRAC_W+COV_W-1:FRAC_W];
      end

      for (int a = 0; a < AXES; a++) begin
         if (cmd.prime)
            est_in[a] = {sample_ff[a], 16'h0000};
         else if (cmd.acc_axis && (AXIS_W'(a) == cmd.axis))
            est_in[a] = est_ff[a] + delta;
      end

      if (cmd.out_load) begin
         for (int a = 0; a < AXES; a++)
            out_in[a] = round_est(est_ff[a]);
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      est_ff    <= est_in;
      cov_ff    <= cov_in;
      e1_ff     <= e1_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      k_ff      <= k_in;
      prod_ff   <= prod_in;
      out_ff    <= out_in;
   end

   assign status.primed   = primed_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign filtered        = out_ff;
   assign rsp_valid       = rsp_valid_ff;

   `SKF3_ASSERT_IMPLY(a_gain_le_one, clock, reset, cmd.mul_axis || cmd.mul_cov,
      k_ff <= GAIN_ONE, "gain above 1.0")
   `SKF3_ASSERT_NEXT(a_out_valid, clock, reset, cmd.out_load, rsp_valid_ff,
      "result register not valid after load")
endmodule

// ===== rtl/skf3_ctrl.sv =====
// Controller: sequences prime, gain division, per-axis update, covariance update, output.
module skf3_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  skf3_pkg::skf3_status_type   status,
   output skf3_pkg::skf3_cmd_type      cmd
);
   import skf3_pkg::*;
   `include "scalar_kalman_filter_3axis_defines.svh"

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PRIME = 4'd1;
   localparam logic [3:0] S_SETUP = 4'd2;
   localparam logic [3:0] S_DIV   = 4'd3;
   localparam logic [3:0] S_MUL   = 4'd4;
   localparam logic [3:0] S_ACC   = 4'd5;
   localparam logic [3:0] S_CMUL  = 4'd6;
   localparam logic [3:0] S_CWR   = 4'd7;
   localparam logic [3:0] S_OUT   = 4'd8;

   logic [3:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [AXIS_W-1:0]    axis_ff, axis_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      axis_in  = axis_ff;
      cmd      = '0;
      cmd.axis = axis_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_sample = 1'b1;
               state_in        = status.primed ? S_SETUP : S_PRIME;
            end
         end
         S_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = S_OUT;
         end
         S_SETUP: begin
            cmd.cov_start = 1'b1;
            cnt_in        = '0;
            state_in      = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               axis_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_axis = 1'b1;
            state_in     = S_ACC;
         end
         S_ACC: begin
            cmd.acc_axis = 1'b1;
            axis_in      = axis_ff + 1'b1;
            state_in     = (axis_ff == AXIS_W'(AXES - 1)) ? S_CMUL : S_MUL;
         end
         S_CMUL: begin
            cmd.mul_cov = 1'b1;
            state_in    = S_CWR;
         end
         S_CWR: begin
            cmd.cov_write = 1'b1;
            state_in      = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
      end
   end

   `SKF3_ASSERT_IMPLY(a_div_cnt_range, clock, reset, state_ff == S_DIV,
      cnt_ff <= DIV_CNT_W'(DIV_STEPS - 1), "divider step count out of range")
   `SKF3_ASSERT_NEXT(a_first_primes, clock, reset,
      req_valid && req_ready && !status.primed, state_ff == S_PRIME,
      "first transaction did not prime")
   `SKF3_ASSERT_IMPLY(a_one_cmd, clock, reset, 1'b1,
      $onehot0({cmd.prime, cmd.cov_start, cmd.div_step, cmd.mul_axis,
                cmd.acc_axis, cmd.mul_cov, cmd.cov_write, cmd.out_load}),
      "more than one datapath command")
endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the three-axis scalar Kalman filter.
`timescale 1ns / 100ps

module tb;
   import skf3_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int SEG_ITEMS  = 72;
   localparam int SEGS       = 4;
   localparam int PHASES     = 4;
   localparam int DRAIN_WAIT = 40;

   typedef enum logic {ROW_CSR, ROW_SAMPLE} row_kind_type;

   typedef struct {
      row_kind_type         kind;
      logic [CSR_IDX_W-1:0] idx;
      logic [CFG_W-1:0]     data;
      axis_vec_type         smp;
      bit                   fixed;
      axis_vec_type         exp;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   skf3_req_if req_bus ();
   skf3_rsp_if rsp_bus ();

   scalar_kalman_filter_3axis dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_bus),
      .rsp_ch       (rsp_bus),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #5 clock = ~clock;

   // predictor state and register copies
   logic                    est_primed;
   logic signed [EST_W-1:0] est [AXES];
   logic [COV_W-1:0]        cov;
   logic [CFG_W-1:0]        cfg_q;
   logic [CFG_W-1:0]        cfg_r;
   logic [CFG_W-1:0]        cfg_p;

   axis_vec_type            expected_filtered [$];
   stim_row_type            dir_tab [$];
   logic                    row_fixed;
   axis_vec_type            row_exp;
   logic signed [SAMPLE_W-1:0] track [AXES];
   int                      send_idle_pct;
   int                      recv_stall_pct;
   int                      mismatch_cnt;

   function automatic axis_vec_type axes3(input logic [SAMPLE_W-1:0] x, y, z);
      axis_vec_type v;
      v[0] = x;
      v[1] = y;
      v[2] = z;
      return v;
   endfunction

   function automatic stim_row_type csr_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] data);
      stim_row_type r;
      r.kind  = ROW_CSR;
      r.idx   = idx;
      r.data  = data;
      r.smp   = '0;
      r.fixed = 1'b0;
      r.exp   = '0;
      return r;
   endfunction

   function automatic stim_row_type smp_row(input axis_vec_type smp, input bit fixed,
                                            input axis_vec_type exp);
      stim_row_type r;
      r.kind  = ROW_SAMPLE;
      r.idx   = '0;
      r.data  = '0;
      r.smp   = smp;
      r.fixed = fixed;
      r.exp   = exp;
      return r;
   endfunction

   function automatic axis_vec_type kalman_step(input axis_vec_type smp);
      axis_vec_type       res;
      logic signed [63:0] e1;
      logic signed [63:0] den;
      logic signed [63:0] gain;
      logic signed [63:0] diff;
      logic signed [63:0] delta;
      logic signed [63:0] whole;
      logic [15:0]        frac;
      if (!est_primed) begin
         est_primed = 1'b1;
         cov = {cfg_p, 8'h00};
         for (int a = 0; a < AXES; a++) begin
            est[a] = {smp[a], 16'h0000};
         end
         return smp;
      end
      e1 = 64'(cov) + 64'({cfg_q, 8'h00});
      if (e1 > 64'(COV_MAX)) begin
         e1 = 64'(COV_MAX);
      end
      den  = e1 + 64'({cfg_r, 8'h00});
      gain = (den == 0) ? 64'sd0 : (e1 <<< 20) / den;
      for (int a = 0; a < AXES; a++) begin
         whole  = $signed({smp[a], 16'h0000});
         diff   = whole - est[a];
         delta  = (gain * diff) >>> 20;
         whole  = est[a] + delta;
         est[a] = whole[EST_W-1:0];
         whole  = est[a] >>> 16;
         frac   = est[a][15:0];
         if (frac > 16'h8000 || (frac == 16'h8000 && whole[0])) begin
            whole = whole + 1;
         end
         if (whole > 32767) begin
            whole = 32767;
         end else if (whole < -32768) begin
            whole = -32768;
         end
         res[a] = whole[SAMPLE_W-1:0];
      end
      whole = ((64'sd1 <<< 20) - gain) * e1;
      cov   = whole[43:20];
      return res;
   endfunction

   function automatic axis_vec_type next_sample();
      axis_vec_type v;
      int unsigned  mode;
      mode = $urandom_range(9);
      for (int a = 0; a < AXES; a++) begin
         case (mode)
            6, 7: v[a] = SAMPLE_W'($urandom);
            8: v[a] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            9: begin
               track[a] = SAMPLE_W'($urandom);
               v[a] = track[a];
            end
            default: begin
               // slow signal plus noise
               track[a] = track[a] + SAMPLE_W'($urandom_range(8)) - 16'sd4;
               v[a] = track[a] + SAMPLE_W'($urandom_range(127)) - 16'sd64;
            end
         endcase
      end
      return v;
   endfunction

   task automatic send_sample(input axis_vec_type smp, input bit fixed,
                              input axis_vec_type exp);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_bus.valid    <= 1'b1;
      req_bus.sample_x <= smp[0];
      req_bus.sample_y <= smp[1];
      req_bus.sample_z <= smp[2];
      row_fixed        <= fixed;
      row_exp          <= exp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (expected_filtered.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_PROCESS_NOISE: cfg_q = data;
         CSR_MEASURE_NOISE: cfg_r = data;
         CSR_INITIAL_ERROR: cfg_p = data;
         default: ;
      endcase
   endtask

   task automatic pick_config();
      logic [CFG_W-1:0] q;
      logic [CFG_W-1:0] r;
      case ($urandom_range(4))
         0: q = '0;
         1: q = '1;
         2: q = CFG_W'($urandom);
         default: q = CFG_W'($urandom_range(1023));
      endcase
      case ($urandom_range(5))
         0: r = '0;
         1: r = 16'd1;
         2: r = '1;
         3: r = CFG_W'($urandom);
         default: r = CFG_W'($urandom_range(4095));
      endcase
      write_csr(CSR_PROCESS_NOISE, q);
      write_csr(CSR_MEASURE_NOISE, r);
      if ($urandom_range(3) == 0) write_csr(CSR_INITIAL_ERROR, CFG_W'($urandom));
      if ($urandom_range(3) == 0) write_csr(CSR_UNUSED, CFG_W'($urandom));
   endtask

   always @(posedge clock) begin
      rsp_bus.ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : monitor
      axis_vec_type got;
      axis_vec_type want;
      axis_vec_type pred;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            pred = kalman_step(axes3(req_bus.sample_x, req_bus.sample_y, req_bus.sample_z));
            expected_filtered.push_back(row_fixed ? row_exp : pred);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = axes3(rsp_bus.filtered_x, rsp_bus.filtered_y, rsp_bus.filtered_z);
            if (expected_filtered.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("%0t: unexpected result x=%0d y=%0d z=%0d", $realtime,
                           $signed(got[0]), $signed(got[1]), $signed(got[2]));
            end else begin
               want = expected_filtered.pop_front();
               if (got[0] != want[0] || got[1] != want[1] || got[2] != want[2]) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("%0t: mismatch exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
                              $realtime, $signed(want[0]), $signed(want[1]),
                              $signed(want[2]), $signed(got[0]), $signed(got[1]),
                              $signed(got[2]));
               end
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int idle_pct [PHASES];
      int stall_pct [PHASES];
      int wait_cnt;
      idle_pct  = '{0, 63, 0, 12};
      stall_pct = '{0, 0, 63, 12};
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_data         = '0;
      req_bus.valid    = 1'b0;
      req_bus.sample_x = '0;
      req_bus.sample_y = '0;
      req_bus.sample_z = '0;
      row_fixed        = 1'b0;
      row_exp          = '0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      mismatch_cnt     = 0;
      est_primed       = 1'b0;
      cov              = '0;
      cfg_q            = PROCESS_NOISE_RST;
      cfg_r            = MEASURE_NOISE_RST;
      cfg_p            = INITIAL_ERROR_RST;
      for (int a = 0; a < AXES; a++) begin
         est[a]   = '0;
         track[a] = '0;
      end

      // priming, covariance overflow, zero r, zero denominator, unused index
      dir_tab.push_back(csr_row(CSR_INITIAL_ERROR, 16'hFFFF));
      dir_tab.push_back(smp_row(axes3(16'h8000, 16'h7FFF, 16'h0000), 1'b1,
                                axes3(16'h8000, 16'h7FFF, 16'h0000)));
      dir_tab.push_back(smp_row(axes3(16'h7FFF, 16'h8000, 16'h0001), 1'b0, '0));
      dir_tab.push_back(smp_row(axes3(16'h0000, 16'h0000, 16'h0000), 1'b0, '0));
      dir_tab.push_back(csr_row(CSR_PROCESS_NOISE, 16'hFFFF));
      dir_tab.push_back(smp_row(axes3(16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0, '0));
      dir_tab.push_back(smp_row(axes3(16'h8000, 16'h8000, 16'h8000), 1'b0, '0));
      dir_tab.push_back(csr_row(CSR_MEASURE_NOISE, 16'h0000));
      dir_tab.push_back(smp_row(axes3(16'd1234, -16'sd4321, 16'h7FFF), 1'b1,
                                axes3(16'd1234, -16'sd4321, 16'h7FFF)));
      dir_tab.push_back(csr_row(CSR_PROCESS_NOISE, 16'h0000));
      dir_tab.push_back(smp_row(axes3(16'd100, -16'sd100, 16'd5), 1'b1,
                                axes3(16'd1234, -16'sd4321, 16'h7FFF)));
      dir_tab.push_back(csr_row(CSR_UNUSED, 16'h1234));
      dir_tab.push_back(smp_row(axes3(16'd7, 16'd8, 16'd9), 1'b1,
                                axes3(16'd1234, -16'sd4321, 16'h7FFF)));
      dir_tab.push_back(csr_row(CSR_MEASURE_NOISE, 16'h0001));
      dir_tab.push_back(csr_row(CSR_PROCESS_NOISE, 16'h0001));
      dir_tab.push_back(smp_row(axes3(16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0, '0));
      dir_tab.push_back(csr_row(CSR_INITIAL_ERROR, 16'h0000));
      dir_tab.push_back(csr_row(CSR_MEASURE_NOISE, 16'hFFFF));
      dir_tab.push_back(smp_row(axes3(16'h7FFF, 16'h8000, 16'hFFFF), 1'b0, '0));
      dir_tab.push_back(smp_row(axes3(16'h5555, 16'hAAAA, 16'h0F0F), 1'b0, '0));
      dir_tab.push_back(csr_row(CSR_PROCESS_NOISE, PROCESS_NOISE_RST));
      dir_tab.push_back(csr_row(CSR_MEASURE_NOISE, MEASURE_NOISE_RST));
      dir_tab.push_back(smp_row(axes3(16'h0001, 16'h8001, 16'h7FFE), 1'b0, '0));
      dir_tab.push_back(smp_row(axes3(16'hF0F0, 16'h1111, 16'hC000), 1'b0, '0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         if (dir_tab[i].kind == ROW_CSR)
            write_csr(dir_tab[i].idx, dir_tab[i].data);
         else
            send_sample(dir_tab[i].smp, dir_tab[i].fixed, dir_tab[i].exp);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         send_idle_pct  = idle_pct[ph];
         recv_stall_pct = stall_pct[ph];
         for (int seg = 0; seg < SEGS; seg++) begin
            pick_config();
            for (int n = 0; n < SEG_ITEMS; n++) begin
               send_sample(next_sample(), 1'b0, '0);
            end
         end
      end
      req_bus.valid <= 1'b0;

      for (wait_cnt = 0; expected_filtered.size() != 0 && wait_cnt < 5000; wait_cnt++)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_filtered.size() != 0) begin
         mismatch_cnt++;
         $display("%0d results never arrived", expected_filtered.size());
      end

      if (mismatch_cnt == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/skf3_pkg.sv
rtl/skf3_req_if.sv
rtl/skf3_rsp_if.sv
rtl/skf3_csr.sv
rtl/skf3_datapath.sv
rtl/skf3_ctrl.sv
rtl/scalar_kalman_filter_3axis.sv
bench/tb.sv
